>>> hw/rtl/build_max_heap_macros.svh
// Assertion macros used by the heap builder datapath.
`ifndef BUILD_MAX_HEAP_MACROS_SVH
`define BUILD_MAX_HEAP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/bmh_pkg.sv
// Package with the controller states and the command and status types of the heap builder.
`default_nettype none
package bmh_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD_INIT,
    ST_SIFT_START,
    ST_GET_NODE,
    ST_GET_LEFT,
    ST_GET_RIGHT,
    ST_DECIDE,
    ST_SWAP_BEST,
    ST_NEXT_ROOT,
    ST_EMIT_RD,
    ST_EMIT_PUT
  } state_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_BUILD_INIT,
    OP_SIFT_START,
    OP_GET_NODE,
    OP_GET_LEFT,
    OP_GET_RIGHT,
    OP_DECIDE,
    OP_SWAP_BEST,
    OP_NEXT_ROOT,
    OP_EMIT_RD,
    OP_EMIT_PUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last_fire;
    logic left_in;
    logic right_in;
    logic best_is_node;
    logic root_zero;
    logic out_free;
    logic emit_final;
  } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/bmh_in_if.sv
// Input channel carrying one array element per transaction.
`default_nettype none
interface bmh_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bmh_out_if.sv
// Output channel carrying one heap element per transaction.
`default_nettype none
interface bmh_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] heap_value;
  logic               last_res;
  logic               overflow;

  modport source (output valid, output heap_value, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input heap_value, input last_res, input overflow,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/build_max_heap.sv
// Elements are loaded while the controller is in its load state; after the last one the build
// runs one sift per index from count/2 down to 0, all through the single store port.
// Emission then does a registered store read per element, then loads the output register.
// One array is handled at a time; input is accepted again once the final element is loaded out.
// Reset (synchronous, rst high) empties the store count, clears overflow and the output valid.
`default_nettype none
module build_max_heap #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  bmh_in_if.sink     elem,
  bmh_out_if.source  heap
);
  import bmh_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bmh_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  bmh_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .elem   (elem),
    .heap   (heap)
  );

endmodule
`default_nettype wire

>>> hw/rtl/bmh_datapath.sv
// Datapath of the heap builder: element store, sift registers, counters and output register.
`default_nettype none
module bmh_datapath #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  bmh_pkg::dp_cmd_t   cmd,
  output bmh_pkg::dp_status_t status,
  bmh_in_if.sink             elem,
  bmh_out_if.source          heap
);
  import bmh_pkg::*;
  `include "build_max_heap_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic signed [31:0] node_val;
  logic signed [31:0] best_val;
  logic signed [31:0] wdata;
  logic [CW-1:0]      count;
  logic [CW-1:0]      root;
  logic [CW-1:0]      node;
  logic [CW-1:0]      best_idx;
  logic [CW-1:0]      eidx;
  logic               dropped;
  logic [CW:0]        left_idx;
  logic [CW+1:0]      right_idx;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic               mem_we;
  logic               load_fire;
  logic               has_room;
  logic               out_valid;
  logic signed [31:0] out_value;
  logic               out_last;
  logic               out_ovf;

  assign left_idx  = {node, 1'b1};
  assign right_idx = {1'b0, left_idx} + (CW + 2)'(1);
  assign has_room  = count < CW'(DEPTH);
  assign elem.ready = (cmd.op == OP_LOAD);
  assign load_fire  = elem.valid && elem.ready;

  always_comb begin
    status.last_fire    = load_fire && elem.last;
    status.left_in      = left_idx < {1'b0, count};
    status.right_in     = right_idx < {2'b00, count};
    status.best_is_node = best_idx == node;
    status.root_zero    = root == '0;
    status.out_free     = !out_valid || heap.ready;
    status.emit_final   = ({1'b0, eidx} + (CW + 1)'(1)) == {1'b0, count};
  end

  // Store port selection: at most one write and one registered read per cycle.
  always_comb begin
    mem_we = 1'b0;
    waddr  = count[AW-1:0];
    wdata  = elem.value;
    raddr  = node[AW-1:0];
    unique case (cmd.op)
      OP_LOAD: begin
        mem_we = load_fire && has_room;
      end
      OP_GET_NODE: begin
        raddr = left_idx[AW-1:0];
      end
      OP_GET_LEFT: begin
        raddr = right_idx[AW-1:0];
      end
      OP_DECIDE: begin
        mem_we = !status.best_is_node;
        waddr  = node[AW-1:0];
        wdata  = best_val;
      end
      OP_SWAP_BEST: begin
        mem_we = 1'b1;
        waddr  = best_idx[AW-1:0];
        wdata  = node_val;
      end
      OP_EMIT_RD: begin
        raddr = eidx[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && heap.ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          if (load_fire) begin
            if (has_room) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        OP_BUILD_INIT: begin
          root <= count >> 1;
          node <= count >> 1;
          eidx <= '0;
        end
        OP_GET_NODE: begin
          node_val <= rd_data;
          best_val <= rd_data;
          best_idx <= node;
        end
        OP_GET_LEFT: begin
          if (rd_data > best_val) begin
            best_val <= rd_data;
            best_idx <= left_idx[CW-1:0];
          end
        end
        OP_GET_RIGHT: begin
          if (rd_data > best_val) begin
            best_val <= rd_data;
            best_idx <= right_idx[CW-1:0];
          end
        end
        OP_SWAP_BEST: begin
          node <= best_idx;
        end
        OP_NEXT_ROOT: begin
          if (!status.root_zero) begin
            root <= root - CW'(1);
            node <= root - CW'(1);
          end
        end
        OP_EMIT_PUT: begin
          out_valid <= 1'b1;
          out_value <= rd_data;
          out_last  <= status.emit_final;
          out_ovf   <= dropped;
          eidx      <= eidx + CW'(1);
          // The array is finished once its final element sits in the output register.
          if (status.emit_final) begin
            count   <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign heap.valid      = out_valid;
  assign heap.heap_value = out_value;
  assign heap.last_res   = out_last;
  assign heap.overflow   = out_ovf;

  `BMH_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "element count above store depth")
  `BMH_ASSERT_NOW(a_put_into_empty, cmd.op == OP_EMIT_PUT, !out_valid || heap.ready,
                  "output register overwritten before its transaction")
  `BMH_ASSERT_NOW(a_swap_downward, cmd.op == OP_SWAP_BEST, best_idx > node,
                  "sift swap does not move toward a child")
  `BMH_ASSERT_NEXT(a_clear_after_final, cmd.op == OP_EMIT_PUT && status.emit_final,
                   count == '0 && !dropped, "store not emptied after final element")

endmodule
`default_nettype wire

>>> hw/rtl/bmh_controller.sv
// Controller state machine sequencing load, heap build and emission.
`default_nettype none
module bmh_controller (
  input  logic                clk,
  input  logic                rst,
  input  bmh_pkg::dp_status_t status,
  output bmh_pkg::dp_cmd_t    cmd
);
  import bmh_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (status.last_fire) begin
          state_next = ST_BUILD_INIT;
        end
      end
      ST_BUILD_INIT: begin
        state_next = ST_SIFT_START;
      end
      ST_SIFT_START: begin
        state_next = status.left_in ? ST_GET_NODE : ST_NEXT_ROOT;
      end
      ST_GET_NODE: begin
        state_next = ST_GET_LEFT;
      end
      ST_GET_LEFT: begin
        state_next = status.right_in ? ST_GET_RIGHT : ST_DECIDE;
      end
      ST_GET_RIGHT: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = status.best_is_node ? ST_NEXT_ROOT : ST_SWAP_BEST;
      end
      ST_SWAP_BEST: begin
        state_next = ST_SIFT_START;
      end
      ST_NEXT_ROOT: begin
        state_next = status.root_zero ? ST_EMIT_RD : ST_SIFT_START;
      end
      ST_EMIT_RD: begin
        if (status.out_free) begin
          state_next = ST_EMIT_PUT;
        end
      end
      ST_EMIT_PUT: begin
        state_next = status.emit_final ? ST_LOAD : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      ST_LOAD:       cmd.op = OP_LOAD;
      ST_BUILD_INIT: cmd.op = OP_BUILD_INIT;
      ST_SIFT_START: cmd.op = OP_SIFT_START;
      ST_GET_NODE:   cmd.op = OP_GET_NODE;
      ST_GET_LEFT:   cmd.op = OP_GET_LEFT;
      ST_GET_RIGHT:  cmd.op = OP_GET_RIGHT;
      ST_DECIDE:     cmd.op = OP_DECIDE;
      ST_SWAP_BEST:  cmd.op = OP_SWAP_BEST;
      ST_NEXT_ROOT:  cmd.op = OP_NEXT_ROOT;
      ST_EMIT_RD:    cmd.op = OP_EMIT_RD;
      ST_EMIT_PUT:   cmd.op = OP_EMIT_PUT;
      default:       cmd.op = OP_LOAD;
    endcase
  end

endmodule
`default_nettype wire
